// ===== hw/rtl/dassh_pkg.sv =====
`default_nettype none

package dassh_pkg;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 3;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_STEP_INTERVAL_X = 3'd0,
		CFG_STEP_INTERVAL_Y = 3'd1,
		CFG_BLANK_STEPS     = 3'd2,
		CFG_CHASE_INTERVAL  = 3'd3,
		CFG_CHASE_SPACING   = 3'd4
	} cfg_idx_t;

	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned IntervalW = 16;
	localparam int unsigned BlankW    = 10;
	localparam int unsigned SpacingW  = 8;
	localparam int unsigned PixelW    = 8;

	// register values after reset
	localparam logic [IntervalW-1:0] STEP_INTERVAL_RST  = 16'd1000;
	localparam logic [BlankW-1:0]    BLANK_STEPS_RST    = 10'd200;
	localparam logic [IntervalW-1:0] CHASE_INTERVAL_RST = 16'd20000;
	localparam logic [SpacingW-1:0]  CHASE_SPACING_RST  = 8'd80;

	localparam logic [IntervalW-1:0] ELAPSED_MAX = 16'hFFFF;

	// control from the sequencer to one axis
	typedef struct packed {
		logic start;   // re-arm: load blanking count, clear latch
		logic tick;    // one timebase tick while homing
		logic stall;   // driver stall report for this tick
	} axis_ctl_t;

	// status from one axis back to the sequencer
	typedef struct packed {
		logic step;        // step pulse this tick
		logic latched_nxt; // stall latch after this tick
	} axis_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dual_axis_stall_homing_sequencer.sv =====
`default_nettype none

// Two-axis stall homing sequencer with LED chase pointer.
// Input stream: one request per timebase tick. s_tuser = command
// (0 tick, 1 start homing); s_tdata carries the two driver stall flags.
// Output stream: exactly one result per request, in order: step pulses
// for both axes, busy/done, and the chase redraw with its two pixel
// indexes (zero when no redraw happens).
// A request accepted sits in the input register; its result is loaded
// into the output register when that register is empty or being read.
// Throughput: one request per clock when not stalled; the whole per-tick
// update is a single pass of counters and compares between both registers.
// A stalled receiver holds the output register; the input register still
// takes a request as long as it can move on in the same cycle, so both
// sides stall together only when both registers are full.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once;
// blank_steps is loaded into the axes at each start request.
// Reset clears the valid flags and homing state: idle, no homing, registers at default values.
module dual_axis_stall_homing_sequencer #(
	parameter int unsigned RING_PIXELS = 160
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// slave side
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [7:0]                      s_tdata,  // [0] stall_x, [1] stall_y
	input  wire                             s_tuser,  // [0] command
	// master side
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// [0] step_x, [1] step_y, [2] busy_res, [3] done_res, [4] led_update,
	// [12:5] lead_pixel, [20:13] trail_pixel
	output logic [23:0]                     m_tdata,
	// configuration
	input  wire                             cfg_we,
	input  wire  [dassh_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire  [dassh_pkg::CfgDataW-1:0]  cfg_data
);
	import dassh_pkg::*;

	localparam int unsigned PosW = $clog2(RING_PIXELS);
	localparam int unsigned TabN = 1 << SpacingW;
	localparam logic [PosW-1:0] PosLast = PosW'(RING_PIXELS - 1);
	localparam logic [PosW:0]   Ring    = (PosW+1)'(RING_PIXELS);

	// configuration registers
	logic [IntervalW-1:0] step_interval_x_q;
	logic [IntervalW-1:0] step_interval_y_q;
	logic [BlankW-1:0]    blank_steps_q;
	logic [IntervalW-1:0] chase_interval_q;
	logic [SpacingW-1:0]  chase_spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_x_q <= STEP_INTERVAL_RST;
			step_interval_y_q <= STEP_INTERVAL_RST;
			blank_steps_q     <= BLANK_STEPS_RST;
			chase_interval_q  <= CHASE_INTERVAL_RST;
			chase_spacing_q   <= CHASE_SPACING_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STEP_INTERVAL_X: step_interval_x_q <= cfg_data;
				CFG_STEP_INTERVAL_Y: step_interval_y_q <= cfg_data;
				CFG_BLANK_STEPS:     blank_steps_q     <= cfg_data[BlankW-1:0];
				CFG_CHASE_INTERVAL:  chase_interval_q  <= cfg_data;
				CFG_CHASE_SPACING:   chase_spacing_q   <= cfg_data[SpacingW-1:0];
				default: ;
			endcase
		end
	end

	// spacing reduced modulo the ring, built at elaboration
	logic [PosW-1:0] spc_tab [TabN];
	for (genvar g = 0; g < TabN; g++) begin : g_spc
		assign spc_tab[g] = PosW'(g % RING_PIXELS);
	end

	// input register
	logic valid_s1;
	logic cmd_s1;
	logic stall_x_s1;
	logic stall_y_s1;
	logic advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			stall_x_s1 <= s_tdata[0];
			stall_y_s1 <= s_tdata[1];
		end
	end

	// sequencer state
	logic            active_q;
	logic [IntervalW-1:0] chase_elapsed_q;
	logic [PosW-1:0] chase_pos_q;

	logic start;
	logic tick;
	assign start = advance && cmd_s1;
	assign tick  = advance && !cmd_s1 && active_q;

	// axes
	axis_ctl_t ctl_x, ctl_y;
	axis_sts_t sts_x, sts_y;

	assign ctl_x = '{start: start, tick: tick, stall: stall_x_s1};
	assign ctl_y = '{start: start, tick: tick, stall: stall_y_s1};

	dassh_axis u_axis_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl_x),
		.interval    (step_interval_x_q),
		.blank_steps (blank_steps_q),
		.sts         (sts_x)
	);

	dassh_axis u_axis_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl_y),
		.interval    (step_interval_y_q),
		.blank_steps (blank_steps_q),
		.sts         (sts_y)
	);

	// chase counter and pixel indexes
	logic [IntervalW-1:0] chase_inc;
	logic                 chase_hit;
	logic [PosW:0]        trail_sum;
	logic [PosW-1:0]      trail_pos;
	logic [PosW-1:0]      pos_next;
	logic                 done;

	always_comb begin
		chase_inc = (chase_elapsed_q < ELAPSED_MAX) ? chase_elapsed_q + 1'b1
		                                            : chase_elapsed_q;
		chase_hit = (chase_inc >= chase_interval_q);
		trail_sum = {1'b0, chase_pos_q} + {1'b0, spc_tab[chase_spacing_q]};
		trail_pos = (trail_sum >= Ring) ? PosW'(trail_sum - Ring) : trail_sum[PosW-1:0];
		pos_next  = (chase_pos_q >= PosLast) ? '0 : chase_pos_q + 1'b1;
		done      = tick && sts_x.latched_nxt && sts_y.latched_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			chase_elapsed_q <= '0;
			chase_pos_q     <= '0;
		end else if (start) begin
			active_q        <= 1'b1;
			chase_elapsed_q <= ELAPSED_MAX;
			chase_pos_q     <= '0;
		end else if (tick) begin
			if (done) begin
				active_q <= 1'b0;
			end
			if (chase_hit) begin
				chase_elapsed_q <= '0;
				chase_pos_q     <= pos_next;
			end else begin
				chase_elapsed_q <= chase_inc;
			end
		end
	end

	// result register
	logic            upd;
	logic [PosW+PixelW-1:0] lead_ext;
	logic [PosW+PixelW-1:0] trail_ext;
	logic [23:0]     res;

	always_comb begin
		upd       = tick && chase_hit;
		lead_ext  = {{PixelW{1'b0}}, upd ? chase_pos_q : {PosW{1'b0}}};
		trail_ext = {{PixelW{1'b0}}, upd ? trail_pos : {PosW{1'b0}}};
		res       = '0;
		res[0]    = sts_x.step;
		res[1]    = sts_y.step;
		res[2]    = start || (tick && !done);
		res[3]    = done;
		res[4]    = upd;
		res[12:5] = lead_ext[PixelW-1:0];
		res[20:13] = trail_ext[PixelW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dassh_axis.sv =====
`default_nettype none

module dassh_axis (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  dassh_pkg::axis_ctl_t     ctl,
	input  wire  [dassh_pkg::IntervalW-1:0] interval,
	input  wire  [dassh_pkg::BlankW-1:0]    blank_steps,
	output dassh_pkg::axis_sts_t           sts
);
	import dassh_pkg::*;

	logic [IntervalW-1:0] elapsed_q;
	logic [BlankW-1:0]    blank_left_q;
	logic                 latched_q;

	logic [IntervalW-1:0] cnt_inc;
	logic                 hit;
	logic                 do_latch;
	logic                 do_step;

	// stall latches only once blanking is over; otherwise count toward a step
	always_comb begin
		cnt_inc  = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		hit      = (cnt_inc >= interval);
		do_latch = ctl.tick && !latched_q && ctl.stall && (blank_left_q == '0);
		do_step  = ctl.tick && !latched_q && !do_latch && hit;
		sts.step        = do_step;
		sts.latched_nxt = latched_q || do_latch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '0;
			blank_left_q <= '0;
			latched_q    <= 1'b0;
		end else if (ctl.start) begin
			elapsed_q    <= ELAPSED_MAX;
			blank_left_q <= blank_steps;
			latched_q    <= 1'b0;
		end else if (ctl.tick && !latched_q) begin
			if (do_latch) begin
				latched_q <= 1'b1;
			end else if (hit) begin
				elapsed_q <= '0;
				if (blank_left_q != '0) begin
					blank_left_q <= blank_left_q - 1'b1;
				end
			end else begin
				elapsed_q <= cnt_inc;
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_dual_axis_stall_homing_sequencer.sv =====
`timescale 1ns / 1ps

module tb_dual_axis_stall_homing_sequencer;
	import dassh_pkg::*;

	localparam int RING = 160;

	// request command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// one result, packed as on m_tdata[20:0]
	typedef struct packed {
		logic [PixelW-1:0] trail;
		logic [PixelW-1:0] lead;
		logic              led_update;
		logic              done;
		logic              busy;
		logic              step_y;
		logic              step_x;
	} homing_res_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [0] stall_x, [1] stall_y
	logic                s_tuser;   // [0] command
	logic                m_tvalid;
	logic                m_tready;
	// [0] step_x, [1] step_y, [2] busy_res, [3] done_res, [4] led_update,
	// [12:5] lead_pixel, [20:13] trail_pixel
	logic [23:0]         m_tdata;
	logic                cfg_we;
	cfg_idx_t            cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// register copies
	logic [IntervalW-1:0] ivl_x, ivl_y, chase_ivl;
	logic [BlankW-1:0]    blank_cfg;
	logic [SpacingW-1:0]  spacing;

	// homing state copies
	logic                 homing;
	logic [IntervalW-1:0] el_x, el_y, chase_el;
	logic [BlankW-1:0]    blank_x, blank_y;
	logic                 lat_x, lat_y;
	logic [PixelW-1:0]    chase_pos;

	homing_res_t expected_results[$];
	int          mismatches = 0;
	logic        calm;  // no idling on either side

	dual_axis_stall_homing_sequencer #(
		.RING_PIXELS(RING)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40) begin
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// one tick of a saturating interval counter; hit clears it
	task automatic count_tick(inout logic [IntervalW-1:0] cnt, input logic [IntervalW-1:0] ivl,
			output logic hit);
		logic [IntervalW-1:0] c;
		c = cnt;
		if (c != ELAPSED_MAX) c = c + 1'b1;
		hit = (c >= ivl);
		cnt = hit ? '0 : c;
	endtask

	// stall latch first, then stepping; blanking counts down per step
	task automatic axis_tick(input logic stall, input logic [IntervalW-1:0] ivl,
			inout logic [IntervalW-1:0] el, inout logic [BlankW-1:0] blank_left,
			inout logic latched, output logic step);
		logic hit;
		step = 1'b0;
		if (!latched) begin
			if (stall && blank_left == '0) begin
				latched = 1'b1;
			end else begin
				count_tick(el, ivl, hit);
				if (hit) begin
					if (blank_left != '0) blank_left = blank_left - 1'b1;
					step = 1'b1;
				end
			end
		end
	endtask

	task automatic predict_homing(input logic cmd, input logic sx, input logic sy,
			output homing_res_t r);
		logic hit;
		int   pos;
		r = '0;
		if (cmd == CMD_START) begin
			homing    = 1'b1;
			el_x      = ELAPSED_MAX;
			el_y      = ELAPSED_MAX;
			chase_el  = ELAPSED_MAX;
			blank_x   = blank_cfg;
			blank_y   = blank_cfg;
			lat_x     = 1'b0;
			lat_y     = 1'b0;
			chase_pos = '0;
			r.busy    = 1'b1;
		end else if (homing) begin
			axis_tick(sx, ivl_x, el_x, blank_x, lat_x, r.step_x);
			axis_tick(sy, ivl_y, el_y, blank_y, lat_y, r.step_y);
			count_tick(chase_el, chase_ivl, hit);
			if (hit) begin
				pos          = int'(chase_pos) % RING;
				r.led_update = 1'b1;
				r.lead       = PixelW'(pos);
				r.trail      = PixelW'((pos + int'(spacing) % RING) % RING);
				pos++;
				if (pos >= RING) pos = 0;
				chase_pos = PixelW'(pos);
			end
			if (lat_x && lat_y) begin
				homing = 1'b0;
				r.done = 1'b1;
			end else begin
				r.busy = 1'b1;
			end
		end
	endtask

	// monitor: check results, track register writes, predict accepted requests
	always @(posedge clk) begin
		homing_res_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = homing_res_t'(m_tdata[20:0]);
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", int'(m_tdata), -1);
				end else begin
					want = expected_results.pop_front();
					if (got.step_x !== want.step_x)
						report_mismatch("step_x", got.step_x, want.step_x);
					if (got.step_y !== want.step_y)
						report_mismatch("step_y", got.step_y, want.step_y);
					if (got.busy !== want.busy)
						report_mismatch("busy_res", got.busy, want.busy);
					if (got.done !== want.done)
						report_mismatch("done_res", got.done, want.done);
					if (got.led_update !== want.led_update)
						report_mismatch("led_update", got.led_update, want.led_update);
					if (got.lead !== want.lead)
						report_mismatch("lead_pixel", got.lead, want.lead);
					if (got.trail !== want.trail)
						report_mismatch("trail_pixel", got.trail, want.trail);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP_INTERVAL_X: ivl_x = cfg_data[IntervalW-1:0];
					CFG_STEP_INTERVAL_Y: ivl_y = cfg_data[IntervalW-1:0];
					CFG_BLANK_STEPS:     blank_cfg = cfg_data[BlankW-1:0];
					CFG_CHASE_INTERVAL:  chase_ivl = cfg_data[IntervalW-1:0];
					CFG_CHASE_SPACING:   spacing = cfg_data[SpacingW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_homing(s_tuser, s_tdata[0], s_tdata[1], want);
				expected_results.push_back(want);
			end
		end
	end

	// receiver: random stall before each result
	initial begin
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = calm ? 0 : $urandom_range(0, 10);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// one request, after a random gap; returns at the falling edge after acceptance
	task automatic send_req(input logic cmd, input logic sx, input logic sy);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'd0, sy, sx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold off requests until every expected result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic write_cfg(input logic [IntervalW-1:0] ivx, input logic [IntervalW-1:0] ivy,
			input logic [BlankW-1:0] blk, input logic [IntervalW-1:0] civ,
			input logic [SpacingW-1:0] sp);
		put_reg(CFG_STEP_INTERVAL_X, CfgDataW'(ivx));
		put_reg(CFG_STEP_INTERVAL_Y, CfgDataW'(ivy));
		put_reg(CFG_BLANK_STEPS, CfgDataW'(blk));
		put_reg(CFG_CHASE_INTERVAL, CfgDataW'(civ));
		put_reg(CFG_CHASE_SPACING, CfgDataW'(sp));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [IntervalW-1:0] pick_interval();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return ELAPSED_MAX;
			2: return IntervalW'($urandom_range(1, 65535));
			3: return IntervalW'($urandom_range(5, 40));
			default: return IntervalW'($urandom_range(1, 4));
		endcase
	endfunction

	// reset values, idle ticks, start with stalls, re-arm while active
	task automatic test_idle_and_defaults();
		calm = 1'b0;
		send_req(CMD_TICK, 1'b1, 1'b1);
		send_req(CMD_TICK, 1'b0, 1'b0);
		send_req(CMD_START, 1'b1, 1'b1);
		send_req(CMD_TICK, 1'b1, 1'b1);
		send_req(CMD_TICK, 1'b0, 1'b1);
		send_req(CMD_TICK, 1'b1, 1'b0);
		send_req(CMD_START, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b0, 1'b0);
		drain_results();
	endtask

	// zero and full intervals, no blanking, spacing past the ring
	task automatic test_extreme_settings();
		write_cfg('0, ELAPSED_MAX, '0, '0, 8'd255);
		send_req(CMD_START, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b1, 1'b0);
		send_req(CMD_TICK, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b0, 1'b1);
		send_req(CMD_TICK, 1'b1, 1'b1);
		drain_results();
		write_cfg(16'd1, 16'd1, 10'd1, ELAPSED_MAX, 8'd160);
		send_req(CMD_START, 1'b1, 1'b1);
		send_req(CMD_TICK, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b1, 1'b1);
		drain_results();
	endtask

	// intervals change at once, blanking only from the next start
	task automatic test_settings_while_homing();
		write_cfg(16'd2, 16'd3, 10'd2, 16'd2, 8'd10);
		send_req(CMD_START, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b1, 1'b0);
		send_req(CMD_TICK, 1'b1, 1'b1);
		send_req(CMD_TICK, 1'b0, 1'b1);
		drain_results();
		write_cfg(16'd1, 16'd1, 10'd5, 16'd1, 8'd150);
		send_req(CMD_TICK, 1'b0, 1'b0);
		send_req(CMD_TICK, 1'b1, 1'b0);
		send_req(CMD_START, 1'b0, 1'b1);
		send_req(CMD_TICK, 1'b1, 1'b1);
		send_req(CMD_TICK, 1'b1, 1'b1);
		drain_results();
	endtask

	// longest blanking at one step per tick; chase wraps the ring many times
	task automatic test_max_blanking();
		int n;
		calm = 1'b1;
		write_cfg(16'd1, '0, 10'd1023, 16'd1, 8'd159);
		send_req(CMD_START, 1'b0, 1'b0);
		n = 0;
		while (homing) begin
			if (n >= 1000) send_req(CMD_TICK, 1'b1, 1'b1);
			else send_req(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			n++;
		end
		drain_results();
		calm = 1'b0;
	endtask

	// random sessions: mostly start then ticks until done, some noise
	task automatic test_random_homing();
		int   counted, kind, rate, maxlen, n;
		logic cmd;
		counted = 0;
		while (counted < 100) begin
			calm = ($urandom_range(0, 4) == 0);
			write_cfg(pick_interval(), pick_interval(),
				($urandom_range(0, 7) == 0) ? BlankW'($urandom_range(0, 1023))
					: BlankW'($urandom_range(0, 8)),
				pick_interval(), SpacingW'($urandom_range(0, 255)));
			kind = $urandom_range(0, 9);
			if (kind <= 7) begin
				rate   = $urandom_range(1, 5);
				maxlen = $urandom_range(10, 80);
				send_req(CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				counted++;
				for (n = 0; n < maxlen && homing; n++) begin
					if ($urandom_range(0, 39) == 0)
						send_req(CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					else
						send_req(CMD_TICK, $urandom_range(0, rate) == 0,
							$urandom_range(0, rate) == 0);
					counted++;
				end
			end else begin
				repeat ($urandom_range(5, 15)) begin
					cmd = ($urandom_range(0, 7) == 0) ? CMD_START : CMD_TICK;
					counted++;
					send_req(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
			drain_results();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = CMD_TICK;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_STEP_INTERVAL_X;
		cfg_data  = '0;
		calm      = 1'b0;
		ivl_x     = STEP_INTERVAL_RST;
		ivl_y     = STEP_INTERVAL_RST;
		blank_cfg = BLANK_STEPS_RST;
		chase_ivl = CHASE_INTERVAL_RST;
		spacing   = CHASE_SPACING_RST;
		homing    = 1'b0;
		el_x      = '0;
		el_y      = '0;
		chase_el  = '0;
		blank_x   = '0;
		blank_y   = '0;
		lat_x     = 1'b0;
		lat_y     = 1'b0;
		chase_pos = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_and_defaults();
		test_extreme_settings();
		test_settings_while_homing();
		test_max_blanking();
		test_random_homing();

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== dual_axis_stall_homing_sequencer.f =====
hw/rtl/dassh_pkg.sv
hw/rtl/dassh_axis.sv
hw/rtl/dual_axis_stall_homing_sequencer.sv
dv/tb_dual_axis_stall_homing_sequencer.sv
